[rtl/core/p2ps_pkg.sv]
`timescale 1ns / 1ps

package p2ps_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // frame size registers and pixel coordinates
    localparam int REG_W      = 11;
    localparam int ROW_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_RESET  = 1024;
    localparam int MAX_W_EVEN = MAX_WIDTH - (MAX_WIDTH % 2);

    localparam int LUMA_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int CHROMA_DEPTH = (MAX_WIDTH / 2) * ((MAX_HEIGHT + 1) / 2);
    localparam int LUMA_AW      = $clog2(LUMA_DEPTH);
    localparam int CHROMA_AW    = $clog2(CHROMA_DEPTH);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int TADDR_W  = 26;
    localparam int TROW_W   = 12;
    localparam int TROW_TOP = 4095;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT
    } t_cfg_reg;

    typedef enum logic [1:0] {
        CMD_Y,
        CMD_U,
        CMD_V
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [7:0]         data;
        logic [LUMA_AW-1:0] addr;      // Y: luma index, U/V: chroma index
        logic [LUMA_AW-1:0] lbase;     // V: luma index of top left pixel
        logic [REG_W-1:0]   width;
        logic [ROW_W-1:0]   row0;
        logic [ROW_W-1:0]   col0;
        logic               two_rows;
        logic               done;
    } t_cmd;

endpackage

[rtl/core/p2ps_front.sv]
`timescale 1ns / 1ps

module p2ps_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [p2ps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [p2ps_pkg::REG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_stream_byte,
    input  logic                           i_q_full,
    output logic                           o_push,
    output p2ps_pkg::t_cmd                 o_cmd
);
    import p2ps_pkg::*;

    typedef enum logic [1:0] {
        PH_Y,
        PH_U,
        PH_V
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [LUMA_AW-1:0] r_count, n_count;
    logic [ROW_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [LUMA_AW-1:0] r_lrow, n_lrow;
    logic [REG_W-1:0]   r_cur_w, n_cur_w;
    logic [REG_W-1:0]   r_cur_h, n_cur_h;
    logic [REG_W-1:0]   r_cfg_w;
    logic [REG_W-1:0]   r_cfg_h;

    logic [REG_W-1:0]   eff_w, eff_h, w_now, h_now, hh_p1;
    logic [ROW_W-1:0]   hw, hh;
    logic               first, y_col_end, y_row_end, c_col_end, c_row_end;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_q_full;
    assign o_push      = i_in_valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= REG_W'(CFG_RESET);
            r_cfg_h <= REG_W'(CFG_RESET);
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_FRAME_WIDTH:  r_cfg_w <= i_cfg_data;
                REG_FRAME_HEIGHT: r_cfg_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp the size registers into the legal range
    always_comb begin
        eff_w = r_cfg_w & ~REG_W'(1);
        if (eff_w < REG_W'(2)) eff_w = REG_W'(2);
        if (int'(eff_w) > MAX_W_EVEN) eff_w = REG_W'(MAX_W_EVEN);
        eff_h = r_cfg_h;
        if (eff_h < REG_W'(1)) eff_h = REG_W'(1);
        if (int'(eff_h) > MAX_HEIGHT) eff_h = REG_W'(MAX_HEIGHT);
    end

    always_comb begin
        first     = (r_count == '0);
        w_now     = first ? eff_w : r_cur_w;
        h_now     = first ? eff_h : r_cur_h;
        y_col_end = (REG_W'(r_col) == w_now - REG_W'(1));
        y_row_end = (REG_W'(r_row) == h_now - REG_W'(1));
        hw        = r_cur_w[REG_W-1:1];
        hh_p1     = r_cur_h + REG_W'(1);
        hh        = hh_p1[REG_W-1:1];
        c_col_end = (r_col == hw - ROW_W'(1));
        c_row_end = (r_row == hh - ROW_W'(1));

        o_cmd.data     = i_stream_byte;
        o_cmd.addr     = r_count;
        o_cmd.lbase    = r_lrow + LUMA_AW'({r_col, 1'b0});
        o_cmd.width    = r_cur_w;
        o_cmd.row0     = {r_row[ROW_W-2:0], 1'b0};
        o_cmd.col0     = {r_col[ROW_W-2:0], 1'b0};
        o_cmd.two_rows = !(r_cur_h[0] && c_row_end);
        o_cmd.done     = c_row_end && c_col_end;

        n_phase = r_phase;
        n_count = r_count + LUMA_AW'(1);
        n_col   = r_col + ROW_W'(1);
        n_row   = r_row;
        n_lrow  = r_lrow;
        n_cur_w = r_cur_w;
        n_cur_h = r_cur_h;

        case (r_phase)
            PH_U: begin
                o_cmd.kind = CMD_U;
                if (c_col_end) begin
                    n_col = '0;
                    n_row = r_row + ROW_W'(1);
                    if (c_row_end) begin
                        n_phase = PH_V;
                        n_count = '0;
                        n_row   = '0;
                        n_lrow  = '0;
                    end
                end
            end
            PH_V: begin
                o_cmd.kind = CMD_V;
                if (c_col_end) begin
                    n_col  = '0;
                    n_row  = r_row + ROW_W'(1);
                    n_lrow = r_lrow + LUMA_AW'({r_cur_w, 1'b0});
                    if (c_row_end) begin
                        n_phase = PH_Y;
                        n_count = '0;
                        n_row   = '0;
                        n_lrow  = '0;
                    end
                end
            end
            default: begin
                // Y plane; frame size is taken on its first byte
                o_cmd.kind = CMD_Y;
                n_phase    = PH_Y;
                if (first) begin
                    n_cur_w = eff_w;
                    n_cur_h = eff_h;
                end
                if (y_col_end) begin
                    n_col = '0;
                    n_row = r_row + ROW_W'(1);
                    if (y_row_end) begin
                        n_phase = PH_U;
                        n_count = '0;
                        n_row   = '0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_Y;
            r_count <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_lrow  <= '0;
            r_cur_w <= REG_W'(CFG_RESET);
            r_cur_h <= REG_W'(CFG_RESET);
        end else if (o_push) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_col   <= n_col;
            r_row   <= n_row;
            r_lrow  <= n_lrow;
            r_cur_w <= n_cur_w;
            r_cur_h <= n_cur_h;
        end
    end

endmodule

[rtl/core/p2ps_queue.sv]
`timescale 1ns / 1ps

module p2ps_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  p2ps_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_head_valid,
    output p2ps_pkg::t_cmd o_head
);
    import p2ps_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_pop;

    assign o_full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head_valid;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (do_pop) r_rd_ptr <= ptr_inc(r_rd_ptr);
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/core/p2ps_back.sv]
`timescale 1ns / 1ps

module p2ps_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_head_valid,
    input  p2ps_pkg::t_cmd                       i_head,
    output logic                                 o_pop,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [p2ps_pkg::ROW_W-1:0]           o_pixel_row,
    output logic [p2ps_pkg::ROW_W-1:0]           o_pixel_col,
    output logic [7:0]                           o_luma,
    output logic [7:0]                           o_chroma_u,
    output logic [7:0]                           o_chroma_v,
    output logic [p2ps_pkg::TADDR_W-1:0]         o_table_address,
    output logic                                 o_last_of_block,
    output logic                                 o_frame_done
);
    import p2ps_pkg::*;

    logic [7:0] r_luma_mem   [LUMA_DEPTH];
    logic [7:0] r_chroma_mem [CHROMA_DEPTH];

    logic [1:0]         r_pix;
    logic               r_s1_valid;
    logic [ROW_W-1:0]   r_s1_row;
    logic [ROW_W-1:0]   r_s1_col;
    logic [7:0]         r_s1_v;
    logic               r_s1_last;
    logic               r_s1_done;
    logic [7:0]         r_y_rd;
    logic [7:0]         r_u_rd;

    logic               r_out_valid;
    logic [ROW_W-1:0]   r_out_row;
    logic [ROW_W-1:0]   r_out_col;
    logic [7:0]         r_out_y;
    logic [7:0]         r_out_u;
    logic [7:0]         r_out_v;
    logic [TADDR_W-1:0] r_out_taddr;
    logic               r_out_last;
    logic               r_out_done;

    logic               adv, is_v, pix_last;
    logic               luma_we, luma_re, chroma_we, chroma_re;
    logic [LUMA_AW-1:0] luma_raddr;
    logic [TROW_W-1:0]  trow;
    logic [23:0]        tidx;
    logic [TADDR_W-1:0] taddr;

    // the whole back end moves only when the output register can take a word
    assign adv      = !r_out_valid || !i_out_stall;
    assign is_v     = i_head_valid && (i_head.kind == CMD_V);
    assign pix_last = i_head.two_rows ? (r_pix == 2'd3) : (r_pix == 2'd1);
    assign o_pop    = adv && i_head_valid && (i_head.kind != CMD_V || pix_last);

    assign luma_we   = adv && i_head_valid && (i_head.kind == CMD_Y);
    assign chroma_we = adv && i_head_valid && (i_head.kind == CMD_U);
    assign luma_re   = adv && is_v;
    assign chroma_re = adv && is_v && (r_pix == 2'd0);

    assign luma_raddr = i_head.lbase
                      + (r_pix[1] ? LUMA_AW'(i_head.width) : '0)
                      + LUMA_AW'(r_pix[0]);

    always_ff @(posedge i_clk) begin
        if (luma_we) r_luma_mem[i_head.addr] <= i_head.data;
        if (luma_re) r_y_rd <= r_luma_mem[luma_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (chroma_we) r_chroma_mem[i_head.addr[CHROMA_AW-1:0]] <= i_head.data;
        if (chroma_re) r_u_rd <= r_chroma_mem[i_head.addr[CHROMA_AW-1:0]];
    end

    // colour table address: 3 * {4095 - (16V + Y>>4), U, Y[3:0]}
    always_comb begin
        trow  = TROW_W'(TROW_TOP) - ({r_s1_v, 4'b0} + TROW_W'(r_y_rd[7:4]));
        tidx  = {trow, r_u_rd, r_y_rd[3:0]};
        taddr = {1'b0, tidx, 1'b0} + TADDR_W'(tidx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= is_v;
            r_out_valid <= r_s1_valid;
            if (is_v) r_pix <= pix_last ? 2'd0 : r_pix + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_row    <= i_head.row0 + ROW_W'(r_pix[1]);
            r_s1_col    <= i_head.col0 + ROW_W'(r_pix[0]);
            r_s1_v      <= i_head.data;
            r_s1_last   <= pix_last;
            r_s1_done   <= i_head.done && pix_last;
            r_out_row   <= r_s1_row;
            r_out_col   <= r_s1_col;
            r_out_y     <= r_y_rd;
            r_out_u     <= r_u_rd;
            r_out_v     <= r_s1_v;
            r_out_taddr <= taddr;
            r_out_last  <= r_s1_last;
            r_out_done  <= r_s1_done;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pixel_row     = r_out_row;
    assign o_pixel_col     = r_out_col;
    assign o_luma          = r_out_y;
    assign o_chroma_u      = r_out_u;
    assign o_chroma_v      = r_out_v;
    assign o_table_address = r_out_taddr;
    assign o_last_of_block = r_out_last;
    assign o_frame_done    = r_out_done;

endmodule

[rtl/core/i420_planar_to_pixel_stream_unit.sv]
`timescale 1ns / 1ps

// I420 planar frame in, one pixel word per cycle out while i_out_stall is low.
// Input channel (i_in_valid / o_in_stall / i_stream_byte) takes the Y plane,
// then the U plane, then the V plane of a frame, one byte per word. Y and U
// bytes are written into the luma and chroma stores and give no output.
// Each V byte gives the 2x2 block it covers (two pixels in the last row of an
// odd-height frame), top left, top right, bottom left, bottom right.
// Frame size comes from the config port (index 0 width, index 1 height) and
// is sampled on the first Y byte of a frame; o_cfg_ready is always high.
// Throughput: Y and U bytes one per cycle while the queue is not full; a V
// byte keeps the back end for one read per pixel, set by the single read
// port of the luma store. A 4-entry command queue lets the input keep taking
// bytes while earlier blocks are still being expanded.
// Path: with the queue empty and no stall, a V byte goes from the queue head
// through the s1 registers and the output register to the output.
// Reset clears control state only; the stores are not cleared, so there is
// no startup sweep. While i_out_stall is high and a word is valid, the word
// holds, the back end freezes, and once the queue fills o_in_stall rises.
module i420_planar_to_pixel_stream_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [p2ps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [p2ps_pkg::REG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_stream_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [p2ps_pkg::ROW_W-1:0]     o_pixel_row,
    output logic [p2ps_pkg::ROW_W-1:0]     o_pixel_col,
    output logic [7:0]                     o_luma,
    output logic [7:0]                     o_chroma_u,
    output logic [7:0]                     o_chroma_v,
    output logic [p2ps_pkg::TADDR_W-1:0]   o_table_address,
    output logic                           o_last_of_block,
    output logic                           o_frame_done
);
    import p2ps_pkg::*;

    logic q_push, q_full, q_pop, q_head_valid;
    t_cmd front_cmd, q_head;

    p2ps_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_stream_byte (i_stream_byte),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_cmd         (front_cmd)
    );

    p2ps_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_cmd        (front_cmd),
        .o_full       (q_full),
        .i_pop        (q_pop),
        .o_head_valid (q_head_valid),
        .o_head       (q_head)
    );

    p2ps_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (q_head_valid),
        .i_head          (q_head),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pixel_row     (o_pixel_row),
        .o_pixel_col     (o_pixel_col),
        .o_luma          (o_luma),
        .o_chroma_u      (o_chroma_u),
        .o_chroma_v      (o_chroma_v),
        .o_table_address (o_table_address),
        .o_last_of_block (o_last_of_block),
        .o_frame_done    (o_frame_done)
    );

    // end of frame is always the end of a block
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_done |-> o_last_of_block)
        else $error("frame_done without last_of_block");

    // pixels of one block leave back to back
    a_block_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_of_block |=> o_out_valid)
        else $error("gap inside a 2x2 block");

    // a new frame needs Y and U bytes before any pixel, so a bubble follows
    a_frame_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_frame_done |=> !o_out_valid)
        else $error("pixel right after end of frame");

    // the queue is popped only when it holds a word
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_head_valid)
        else $error("pop from empty queue");

endmodule
